### src/atfm_pkg.sv
// Shared constants and types for the allocation table fragmentation monitor.
`timescale 1ns / 1ps

package atfm_pkg;

    localparam int NUM_OWNERS = 64;
    localparam int ADDR_BITS  = 40;

    localparam int ID_IN_W  = 6;
    localparam int ID_W     = $clog2(NUM_OWNERS);
    localparam int CNT_W    = $clog2(NUM_OWNERS + 1);
    localparam int ADDR_W   = ADDR_BITS;
    localparam int END_W    = ADDR_BITS + 1;
    localparam int USED_W   = ADDR_BITS + 6;
    localparam int REM_W    = END_W + 1;
    localparam int RATIO_W  = 16;
    localparam int STEP_W   = $clog2(RATIO_W);
    localparam int ENTRY_W  = 2 * ADDR_BITS;

    localparam logic [RATIO_W-1:0] WARN_THRESHOLD_RESET = 16'd19661;

    typedef enum logic {
        CMD_RECORD = 1'b0,
        CMD_FREE   = 1'b1
    } t_cmd;

endpackage

### src/atfm_if.sv
// Request and result channel interfaces of the fragmentation monitor.
`timescale 1ns / 1ps

interface atfm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [atfm_pkg::ID_IN_W-1:0] owner_id;
    logic [atfm_pkg::ADDR_W-1:0]  base_addr;
    logic [atfm_pkg::ADDR_W-1:0]  alloc_size;

    modport source (output valid, cmd, owner_id, base_addr, alloc_size, input ready);
    modport sink   (input valid, cmd, owner_id, base_addr, alloc_size, output ready);
endinterface

interface atfm_out_if;
    logic                        valid;
    logic                        ready;
    logic [atfm_pkg::RATIO_W-1:0] unused_ratio;
    logic [atfm_pkg::CNT_W-1:0]   active_count;
    logic                        high_frag;
    logic                        overlap_seen;
    logic [atfm_pkg::USED_W-1:0]  used_total;
    logic [atfm_pkg::END_W-1:0]   highest_end;

    modport source (output valid, unused_ratio, active_count, high_frag, overlap_seen,
                    used_total, highest_end, input ready);
    modport sink   (input valid, unused_ratio, active_count, high_frag, overlap_seen,
                    used_total, highest_end, output ready);
endinterface

### src/atfm_ram.sv
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps

module atfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/alloc_table_fragmentation_monitor.sv
// Top level: allocation table with a serial scan and a serial fractional divider.
// Each request is taken only in the idle state; its result follows the scan, the prepare
// state and the divide, or only the scan and prepare state when the divide is skipped for
// an empty, zero-extent or overlapping table. The scan reads all 64 entries through one
// RAM read port, the prepare state sets up the divide and the restoring divider yields one
// quotient bit a cycle for the 16-bit ratio. One request is in flight at a time: the next
// is taken once the last result is registered, later while a result still waits. Synchronous
// reset empties the table at once through its valid bits and sets the threshold to 19661.
`timescale 1ns / 1ps

module alloc_table_fragmentation_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [atfm_pkg::RATIO_W-1:0]  i_cfg_wdata,
    atfm_in_if.sink                       i_req,
    atfm_out_if.source                    o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    t_state                            r_state;
    logic [atfm_pkg::RATIO_W-1:0]      r_thresh;
    logic [atfm_pkg::NUM_OWNERS-1:0]   r_valid;
    logic [atfm_pkg::CNT_W-1:0]        r_cnt;
    logic                              r_pv;
    logic [atfm_pkg::ID_W-1:0]         r_pidx;
    logic [atfm_pkg::USED_W-1:0]       r_used;
    logic [atfm_pkg::END_W-1:0]        r_high;
    logic [atfm_pkg::CNT_W-1:0]        r_count;
    logic [atfm_pkg::REM_W-1:0]        r_rem;
    logic [atfm_pkg::END_W-1:0]        r_den;
    logic [atfm_pkg::RATIO_W-1:0]      r_quot;
    logic [atfm_pkg::STEP_W-1:0]       r_step;
    logic                              r_ovl;

    logic                              r_o_valid;
    logic [atfm_pkg::RATIO_W-1:0]      r_o_ratio;
    logic [atfm_pkg::CNT_W-1:0]        r_o_count;
    logic                              r_o_high_frag;
    logic                              r_o_overlap;
    logic [atfm_pkg::USED_W-1:0]       r_o_used;
    logic [atfm_pkg::END_W-1:0]        r_o_high;

    logic                              id_ok;
    logic                              req_fire;
    logic                              ram_we;
    logic [atfm_pkg::ENTRY_W-1:0]      ram_wdata;
    logic [atfm_pkg::ENTRY_W-1:0]      ram_rdata;
    logic [atfm_pkg::ADDR_W-1:0]       rd_start;
    logic [atfm_pkg::ADDR_W-1:0]       rd_size;
    logic [atfm_pkg::END_W-1:0]        rd_end;
    logic                              used_over;
    logic [atfm_pkg::REM_W-1:0]        n_rem_shift;
    logic [atfm_pkg::REM_W-1:0]        n_rem_diff;
    logic                              n_rem_ge;

    always_comb begin
        id_ok     = (atfm_pkg::CNT_W'(i_req.owner_id) < atfm_pkg::CNT_W'(atfm_pkg::NUM_OWNERS));
        req_fire  = i_req.valid && (r_state == S_IDLE);
        ram_we    = req_fire && id_ok && (i_req.cmd == atfm_pkg::CMD_RECORD);
        ram_wdata = {i_req.base_addr, i_req.alloc_size};
        rd_start  = ram_rdata[atfm_pkg::ENTRY_W-1:atfm_pkg::ADDR_W];
        rd_size   = ram_rdata[atfm_pkg::ADDR_W-1:0];
        rd_end    = {1'b0, rd_start} + {1'b0, rd_size};
        used_over = (r_used > atfm_pkg::USED_W'(r_high));
        n_rem_shift = {r_rem[atfm_pkg::REM_W-2:0], 1'b0};
        n_rem_ge    = (n_rem_shift >= {1'b0, r_den});
        n_rem_diff  = n_rem_shift - {1'b0, r_den};
    end

    atfm_ram #(
        .WIDTH (atfm_pkg::ENTRY_W),
        .DEPTH (atfm_pkg::NUM_OWNERS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_req.owner_id[atfm_pkg::ID_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[atfm_pkg::ID_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_thresh  <= atfm_pkg::WARN_THRESHOLD_RESET;
            r_valid   <= '0;
            r_cnt     <= '0;
            r_pv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (r_o_valid && o_res.ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        if (id_ok) begin
                            r_valid[i_req.owner_id[atfm_pkg::ID_W-1:0]] <=
                                (i_req.cmd == atfm_pkg::CMD_RECORD);
                        end
                        r_cnt   <= '0;
                        r_used  <= '0;
                        r_high  <= '0;
                        r_count <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pv <= (r_cnt < atfm_pkg::CNT_W'(atfm_pkg::NUM_OWNERS));
                    if (r_cnt < atfm_pkg::CNT_W'(atfm_pkg::NUM_OWNERS)) begin
                        r_pidx <= r_cnt[atfm_pkg::ID_W-1:0];
                        r_cnt  <= r_cnt + atfm_pkg::CNT_W'(1);
                    end
                    if (r_pv && r_valid[r_pidx]) begin
                        r_used  <= r_used + atfm_pkg::USED_W'(rd_size);
                        r_count <= r_count + atfm_pkg::CNT_W'(1);
                        if (rd_end > r_high) begin
                            r_high <= rd_end;
                        end
                    end
                    if (r_pv && (r_pidx == atfm_pkg::ID_W'(atfm_pkg::NUM_OWNERS - 1))) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_ovl  <= used_over;
                    r_quot <= '0;
                    r_step <= '0;
                    r_rem  <= atfm_pkg::REM_W'(r_high - r_used[atfm_pkg::END_W-1:0]);
                    r_den  <= r_high;
                    if (used_over || (r_high == '0)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (n_rem_ge) begin
                        r_rem  <= n_rem_diff;
                        r_quot <= {r_quot[atfm_pkg::RATIO_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= n_rem_shift;
                        r_quot <= {r_quot[atfm_pkg::RATIO_W-2:0], 1'b0};
                    end
                    r_step <= r_step + atfm_pkg::STEP_W'(1);
                    if (r_step == atfm_pkg::STEP_W'(atfm_pkg::RATIO_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || o_res.ready) begin
                        r_o_valid     <= 1'b1;
                        r_o_ratio     <= r_quot;
                        r_o_count     <= r_count;
                        r_o_high_frag <= (r_quot > r_thresh);
                        r_o_overlap   <= r_ovl;
                        r_o_used      <= r_used;
                        r_o_high      <= r_high;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_o_valid;
    assign o_res.unused_ratio = r_o_ratio;
    assign o_res.active_count = r_o_count;
    assign o_res.high_frag    = r_o_high_frag;
    assign o_res.overlap_seen = r_o_overlap;
    assign o_res.used_total   = r_o_used;
    assign o_res.highest_end  = r_o_high;

endmodule

### src/atfm_checker.sv
// Port-level checker for the fragmentation monitor, bound to the top level.
`timescale 1ns / 1ps

module atfm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [atfm_pkg::RATIO_W-1:0]  i_unused_ratio,
    input logic [atfm_pkg::CNT_W-1:0]    i_active_count,
    input logic                          i_high_frag,
    input logic                          i_overlap_seen,
    input logic [atfm_pkg::USED_W-1:0]   i_used_total,
    input logic [atfm_pkg::END_W-1:0]    i_highest_end
);

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while a previous request is still in progress");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_unused_ratio)
            && $stable(i_used_total) && $stable(i_highest_end)))
        else $error("stalled result changed");

    a_overlap_zero_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_overlap_seen) |-> (i_unused_ratio == '0 && !i_high_frag))
        else $error("overlap reported with a non-zero ratio");

    a_empty_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_active_count == '0) |->
            (i_used_total == '0 && i_highest_end == '0 && i_unused_ratio == '0
             && !i_overlap_seen))
        else $error("empty table reported with non-zero totals");

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid directly after reset");

endmodule

bind alloc_table_fragmentation_monitor atfm_checker u_atfm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_unused_ratio (o_res.unused_ratio),
    .i_active_count (o_res.active_count),
    .i_high_frag    (o_res.high_frag),
    .i_overlap_seen (o_res.overlap_seen),
    .i_used_total   (o_res.used_total),
    .i_highest_end  (o_res.highest_end)
);

### test/atfm_result_checker.sv
// Result checker: tracks the allocation table, predicts each result and compares it.
`timescale 1ns / 1ps

module atfm_result_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [atfm_pkg::RATIO_W-1:0] i_cfg_wdata,
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic                         i_req_cmd,
    input  logic [atfm_pkg::ID_IN_W-1:0] i_req_owner_id,
    input  logic [atfm_pkg::ADDR_W-1:0]  i_req_start,
    input  logic [atfm_pkg::ADDR_W-1:0]  i_req_size,
    input  logic                         i_res_valid,
    input  logic                         i_res_ready,
    input  logic [atfm_pkg::RATIO_W-1:0] i_res_unused_ratio,
    input  logic [atfm_pkg::CNT_W-1:0]   i_res_active_count,
    input  logic                         i_res_high_frag,
    input  logic                         i_res_overlap_seen,
    input  logic [atfm_pkg::USED_W-1:0]  i_res_used_total,
    input  logic [atfm_pkg::END_W-1:0]   i_res_highest_end,
    output int                           o_mismatches,
    output int                           o_outstanding
);

    typedef struct packed {
        logic [atfm_pkg::RATIO_W-1:0] unused_ratio;
        logic [atfm_pkg::CNT_W-1:0]   active_count;
        logic                         high_frag;
        logic                         overlap_seen;
        logic [atfm_pkg::USED_W-1:0]  used_total;
        logic [atfm_pkg::END_W-1:0]   highest_end;
    } t_usage;

    logic [atfm_pkg::RATIO_W-1:0] threshold;
    logic                         owner_valid [atfm_pkg::NUM_OWNERS];
    logic [atfm_pkg::ADDR_W-1:0]  owner_start [atfm_pkg::NUM_OWNERS];
    logic [atfm_pkg::ADDR_W-1:0]  owner_size  [atfm_pkg::NUM_OWNERS];
    t_usage                       expected_usage [$];
    int                           mismatches = 0;

    function automatic t_usage summarise_table();
        logic [63:0] used;
        logic [63:0] high;
        logic [63:0] entry_end;
        logic [63:0] quot;
        logic [atfm_pkg::RATIO_W-1:0] ratio;
        int count;
        t_usage r;
        used  = '0;
        high  = '0;
        count = 0;
        ratio = '0;
        r     = '0;
        for (int i = 0; i < atfm_pkg::NUM_OWNERS; i++) begin
            if (owner_valid[i]) begin
                entry_end = 64'(owner_start[i]) + 64'(owner_size[i]);
                used = used + 64'(owner_size[i]);
                if (entry_end > high) begin
                    high = entry_end;
                end
                count++;
            end
        end
        if (used > high) begin
            r.overlap_seen = 1'b1;
        end else if (high != 0) begin
            // A table whose sizes are all zero gives a full-scale quotient, held at all ones.
            quot = ((high - used) << atfm_pkg::RATIO_W) / high;
            if (quot > 64'hFFFF) begin
                quot = 64'hFFFF;
            end
            ratio = quot[atfm_pkg::RATIO_W-1:0];
        end
        r.unused_ratio = ratio;
        r.active_count = count[atfm_pkg::CNT_W-1:0];
        r.high_frag    = (ratio > threshold);
        r.used_total   = used[atfm_pkg::USED_W-1:0];
        r.highest_end  = high[atfm_pkg::END_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_usage got;
        t_usage want;
        if (!i_rst_n) begin
            threshold = atfm_pkg::WARN_THRESHOLD_RESET;
            for (int i = 0; i < atfm_pkg::NUM_OWNERS; i++) begin
                owner_valid[i] = 1'b0;
            end
            expected_usage.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = '{i_res_unused_ratio, i_res_active_count, i_res_high_frag,
                        i_res_overlap_seen, i_res_used_total, i_res_highest_end};
                if (expected_usage.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"Unexpected result: ratio=%0d count=%0d hf=%0b ov=%0b",
                                  " used=%0d high=%0d"},
                                 got.unused_ratio, got.active_count, got.high_frag,
                                 got.overlap_seen, got.used_total, got.highest_end);
                    end
                end else begin
                    want = expected_usage.pop_front();
                    if (got.unused_ratio !== want.unused_ratio
                            || got.active_count !== want.active_count
                            || got.high_frag !== want.high_frag
                            || got.overlap_seen !== want.overlap_seen
                            || got.used_total !== want.used_total
                            || got.highest_end !== want.highest_end) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"Mismatch: expected ratio=%0d count=%0d hf=%0b",
                                      " ov=%0b used=%0d high=%0d"},
                                     want.unused_ratio, want.active_count, want.high_frag,
                                     want.overlap_seen, want.used_total, want.highest_end);
                            $display({"          actual   ratio=%0d count=%0d hf=%0b",
                                      " ov=%0b used=%0d high=%0d"},
                                     got.unused_ratio, got.active_count, got.high_frag,
                                     got.overlap_seen, got.used_total, got.highest_end);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_cmd == atfm_pkg::CMD_RECORD) begin
                    owner_valid[i_req_owner_id] = 1'b1;
                    owner_start[i_req_owner_id] = i_req_start;
                    owner_size[i_req_owner_id]  = i_req_size;
                end else begin
                    owner_valid[i_req_owner_id] = 1'b0;
                end
                expected_usage.push_back(summarise_table());
            end
            if (i_cfg_we) begin
                threshold = i_cfg_wdata;
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_usage.size();
    end

endmodule

### test/alloc_table_fragmentation_monitor_tb.sv
// Testbench top: drives requests, threshold writes and result stalls, and gives the verdict.
`timescale 1ns / 1ps

module alloc_table_fragmentation_monitor_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam logic [atfm_pkg::ADDR_W-1:0] ADDR_MAX = '1;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE,
        READY_BURSTY
    } t_ready_mode;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [atfm_pkg::RATIO_W-1:0] i_cfg_wdata;
    int                           mismatches;
    int                           outstanding;
    int                           cycle_count = 0;
    int                           burst_left = 0;
    t_ready_mode                  ready_mode = READY_ALWAYS;
    int                           ready_mode_left = 0;
    int                           ready_hold_left = 0;

    atfm_in_if  req_if ();
    atfm_out_if res_if ();

    alloc_table_fragmentation_monitor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    atfm_result_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_req_valid        (req_if.valid),
        .i_req_ready        (req_if.ready),
        .i_req_cmd          (req_if.cmd),
        .i_req_owner_id     (req_if.owner_id),
        .i_req_start        (req_if.base_addr),
        .i_req_size         (req_if.alloc_size),
        .i_res_valid        (res_if.valid),
        .i_res_ready        (res_if.ready),
        .i_res_unused_ratio (res_if.unused_ratio),
        .i_res_active_count (res_if.active_count),
        .i_res_high_frag    (res_if.high_frag),
        .i_res_overlap_seen (res_if.overlap_seen),
        .i_res_used_total   (res_if.used_total),
        .i_res_highest_end  (res_if.highest_end),
        .o_mismatches       (mismatches),
        .o_outstanding      (outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (ready_mode_left == 0) begin
            ready_mode      <= t_ready_mode'($urandom_range(0, 3));
            ready_mode_left <= $urandom_range(50, 400);
        end else begin
            ready_mode_left <= ready_mode_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: begin
                res_if.ready <= 1'b1;
            end
            READY_RANDOM: begin
                res_if.ready <= ($urandom_range(0, 9) < 7);
            end
            READY_SPARSE: begin
                res_if.ready <= (cycle_count[1:0] == 2'b00);
            end
            default: begin
                if (ready_hold_left == 0) begin
                    res_if.ready    <= 1'($urandom_range(0, 1));
                    ready_hold_left <= $urandom_range(1, 30);
                end else begin
                    ready_hold_left <= ready_hold_left - 1;
                end
            end
        endcase
    end

    function automatic logic [atfm_pkg::ADDR_W-1:0] random_addr(input int bits);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return atfm_pkg::ADDR_W'(raw & ((64'd1 << bits) - 64'd1));
    endfunction

    task automatic send_request(input atfm_pkg::t_cmd cmd,
                                input logic [atfm_pkg::ID_IN_W-1:0] id,
                                input logic [atfm_pkg::ADDR_W-1:0] start,
                                input logic [atfm_pkg::ADDR_W-1:0] size);
        req_if.valid      <= 1'b1;
        req_if.cmd        <= cmd;
        req_if.owner_id   <= id;
        req_if.base_addr  <= start;
        req_if.alloc_size <= size;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [atfm_pkg::RATIO_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_request(input int free_pct, input bit wide, input int id_hint);
        atfm_pkg::t_cmd                cmd;
        logic [atfm_pkg::ID_IN_W-1:0]  id;
        logic [atfm_pkg::ADDR_W-1:0]   start;
        logic [atfm_pkg::ADDR_W-1:0]   size;
        int                            style;
        cmd   = ($urandom_range(0, 99) < free_pct) ? atfm_pkg::CMD_FREE : atfm_pkg::CMD_RECORD;
        id    = (id_hint >= 0) ? atfm_pkg::ID_IN_W'(id_hint)
                               : atfm_pkg::ID_IN_W'($urandom_range(0, atfm_pkg::NUM_OWNERS - 1));
        style = wide ? 3 * $urandom_range(0, 1) : $urandom_range(0, 4);
        case (style)
            0: begin
                start = random_addr(atfm_pkg::ADDR_W);
                size  = random_addr(atfm_pkg::ADDR_W);
            end
            1: begin
                start = random_addr(20);
                size  = random_addr(12);
            end
            2: begin
                start = random_addr(32);
                size  = random_addr(24);
            end
            3: begin
                start = ADDR_MAX - random_addr(8);
                size  = ADDR_MAX - random_addr(8);
            end
            default: begin
                start = random_addr(16);
                size  = '0;
            end
        endcase
        send_request(cmd, id, start, size);
    endtask

    task automatic run_phase(input int count, input int free_pct, input bit wide,
                             input bit pause_midway);
        int gap;
        for (int k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2) begin
                wait_for_results();
            end
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
                if (gap != 0) begin
                    req_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
            random_request(free_pct, wide, wide ? k % atfm_pkg::NUM_OWNERS : -1);
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        req_if.valid      <= 1'b0;
        req_if.cmd        <= atfm_pkg::CMD_RECORD;
        req_if.owner_id   <= '0;
        req_if.base_addr  <= '0;
        req_if.alloc_size <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, zero highest end, all-zero sizes, overlap and a free of an absent owner.
        send_request(atfm_pkg::CMD_FREE,   6'd5,  40'd0,    40'd0);
        send_request(atfm_pkg::CMD_RECORD, 6'd0,  40'd0,    40'd0);
        send_request(atfm_pkg::CMD_RECORD, 6'd1,  40'd100,  40'd0);
        send_request(atfm_pkg::CMD_RECORD, 6'd2,  40'd0,    40'd100);
        send_request(atfm_pkg::CMD_RECORD, 6'd3,  40'd50,   40'd100);
        send_request(atfm_pkg::CMD_FREE,   6'd3,  ADDR_MAX, ADDR_MAX);
        send_request(atfm_pkg::CMD_FREE,   6'd3,  40'd0,    40'd0);
        send_request(atfm_pkg::CMD_FREE,   6'd1,  40'd0,    40'd0);
        send_request(atfm_pkg::CMD_RECORD, 6'd4,  40'd150,  40'd50);
        send_request(atfm_pkg::CMD_RECORD, 6'd63, ADDR_MAX, ADDR_MAX);
        send_request(atfm_pkg::CMD_RECORD, 6'd62, 40'd0,    ADDR_MAX);
        send_request(atfm_pkg::CMD_RECORD, 6'd0,  ADDR_MAX, 40'd0);
        send_request(atfm_pkg::CMD_FREE,   6'd63, 40'd0,    40'd0);
        send_request(atfm_pkg::CMD_FREE,   6'd62, 40'd0,    40'd0);
        send_request(atfm_pkg::CMD_FREE,   6'd0,  40'd0,    40'd0);
        wait_for_results();

        // The ratio now stands at exactly one quarter; check both sides of the threshold.
        write_threshold(16'd16384);
        send_request(atfm_pkg::CMD_FREE, 6'd9, 40'd0, 40'd0);
        wait_for_results();
        write_threshold(16'd16383);
        send_request(atfm_pkg::CMD_FREE, 6'd9, 40'd0, 40'd0);
        wait_for_results();

        write_threshold(16'd0);
        run_phase(150, 30, 1'b0, 1'b0);
        wait_for_results();
        write_threshold(16'hFFFF);
        run_phase(100, 20, 1'b0, 1'b0);
        wait_for_results();
        write_threshold(atfm_pkg::RATIO_W'($urandom));
        run_phase(100, 0, 1'b1, 1'b0);
        wait_for_results();
        write_threshold(atfm_pkg::WARN_THRESHOLD_RESET);
        run_phase(150, 50, 1'b0, 1'b0);
        wait_for_results();
        write_threshold(atfm_pkg::RATIO_W'($urandom_range(1000, 40000)));
        run_phase(150, 35, 1'b0, 1'b1);
        wait_for_results();
        repeat (200) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
